// ===== design/ptp_correction_field_updater_defines.svh =====
// Assertion macros shared by the PTP correction field updater RTL.
// No dependencies; the checks compile away when SYNTHESIS is defined.
`ifndef PTP_CORRECTION_FIELD_UPDATER_DEFINES_SVH
`define PTP_CORRECTION_FIELD_UPDATER_DEFINES_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define PTPCF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("ptpcf assertion failed");
// Condition must never be seen outside reset.
`define PTPCF_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("ptpcf forbidden condition seen");
`else
`define PTPCF_ASSERT(lbl, clk, rst_n, prop)
`define PTPCF_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== design/ptpcf_pkg.sv =====
// Shared types and constants for the PTP correction field updater.
// No dependencies.
package ptpcf_pkg;

    // seven held-back bytes plus the eight-byte burst leave eight jobs waiting
    localparam int unsigned QueueDepth = 9;

    // byte offsets within the IPv4/UDP/PTPv2 frame
    localparam logic [15:0] OffProtocol = 16'd9;
    localparam logic [15:0] OffPortHi   = 16'd22;
    localparam logic [15:0] OffPortLo   = 16'd23;
    localparam logic [15:0] OffMsgType  = 16'd28;
    localparam logic [15:0] OffVersion  = 16'd29;
    localparam logic [15:0] OffCorrFirst = 16'd36;
    localparam logic [15:0] OffCorrLast  = 16'd43;
    localparam logic [15:0] CorrBase     = 16'd35;
    localparam logic [15:0] OffMax       = 16'hFFFF;
    localparam logic [15:0] MinLength    = 16'd62;

    localparam logic [7:0]  IpProtoUdp  = 8'd17;
    localparam logic [15:0] PortEvent   = 16'd319;
    localparam logic [15:0] PortGeneral = 16'd320;
    localparam logic [7:0]  PtpVersion2 = 8'd2;
    localparam logic [7:0]  MsgSync      = 8'd0;
    localparam logic [7:0]  MsgDelayReq  = 8'd1;
    localparam logic [7:0]  MsgDelayResp = 8'd9;

    localparam logic [3:0] CntPass = 4'd1;
    localparam logic [3:0] CntSum  = 4'd8;

    // one queued job: cnt bytes of data, most significant first
    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  cnt;
        logic        last;
        logic        upd;
    } t_job;

endpackage

// ===== design/ptp_correction_field_updater.sv =====
// Top level of the PTP transparent-clock correction field updater.
// Depends on ptpcf_pkg, ptpcf_front, ptpcf_queue and ptpcf_back.
//
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+----------------------------------------
//  in      | input     | i_in_valid / o_in_stall | i_data_byte, i_last_byte,
//          |           |                        | i_packet_length, i_residence_ns
//  out     | output    | o_out_valid / i_out_stall | o_out_byte, o_out_last, o_was_updated
//
// One input transaction per cycle; the front end never waits on the back end
// unless the job queue is full. Bytes 36..42 of a qualifying packet are absorbed
// and byte 43 releases eight bytes, so the back end's one-byte-per-cycle output
// register sets the sustained rate at one byte per cycle while the output is not stalled.
// A pass-through byte into an empty queue is registered in the queue and then in
// the back end's output register; each job waiting ahead of it delays it further.
// The queue is nine deep, so with a free output the input never stalls.
// Reset (synchronous, active low) empties the queue and clears packet state.
// o_in_stall is high only while the queue is full; a stalled output holds.

module ptp_correction_field_updater #(
    parameter int unsigned QUEUE_DEPTH = ptpcf_pkg::QueueDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input transactions
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic [15:0] i_packet_length,
    input  logic [63:0] i_residence_ns,
    // output transactions
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_out_last,
    output logic        o_was_updated
);
    import ptpcf_pkg::*;

    // front to queue
    logic push;
    t_job push_job;
    logic full;

    // queue to back
    logic pop;
    t_job head;
    logic empty;

    // Parses header bytes, decides qualification at byte 36, gathers the
    // correction field and does the 64-bit add at byte 43.
    ptpcf_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_last_byte     (i_last_byte),
        .i_packet_length (i_packet_length),
        .i_residence_ns  (i_residence_ns),
        .i_full          (full),
        .o_push          (push),
        .o_job           (push_job)
    );

    // Jobs of one to eight bytes; absorbs the burst released at byte 43.
    ptpcf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty)
    );

    // Emits jobs most significant byte first through the output register.
    ptpcf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_empty       (empty),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_out_last    (o_out_last),
        .o_was_updated (o_was_updated)
    );

endmodule

// ===== design/ptpcf_front.sv =====
// Front end: parses header bytes, holds the correction field, queues jobs.
// Depends on ptpcf_pkg.
module ptpcf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    input  logic [15:0]       i_packet_length,
    input  logic [63:0]       i_residence_ns,
    input  logic              i_full,
    output logic              o_push,
    output ptpcf_pkg::t_job   o_job
);
    import ptpcf_pkg::*;

    logic [15:0] r_offset, n_offset;
    logic        r_protocol_ok, n_protocol_ok;
    logic [7:0]  r_port_high, n_port_high;
    logic        r_port_ok, n_port_ok;
    logic        r_type_ok, n_type_ok;
    logic        r_version_ok, n_version_ok;
    logic [63:0] r_hold, n_hold;
    logic        r_holding, n_holding;
    logic        r_updated, n_updated;

    logic        acc;
    logic        hold_start;
    logic        in_field;
    logic [63:0] hold_shift;
    logic [15:0] port;

    assign acc        = i_in_valid && !i_full;
    assign o_in_stall = i_full;
    assign port       = {r_port_high, i_data_byte};

    assign hold_start = (r_offset == OffCorrFirst) && (i_packet_length >= MinLength)
                      && r_protocol_ok && r_port_ok && r_type_ok && r_version_ok;
    assign in_field   = (hold_start || r_holding)
                      && (r_offset >= OffCorrFirst) && (r_offset <= OffCorrLast);
    assign hold_shift = {(hold_start ? 56'd0 : r_hold[55:0]), i_data_byte};

    always_comb begin
        n_offset      = r_offset;
        n_protocol_ok = r_protocol_ok;
        n_port_high   = r_port_high;
        n_port_ok     = r_port_ok;
        n_type_ok     = r_type_ok;
        n_version_ok  = r_version_ok;
        n_hold        = r_hold;
        n_holding     = r_holding;
        n_updated     = r_updated;
        o_push        = 1'b0;
        o_job         = '{data: {56'd0, i_data_byte}, cnt: CntPass,
                          last: i_last_byte, upd: r_updated};

        if (acc) begin
            if (r_offset == OffProtocol) n_protocol_ok = (i_data_byte == IpProtoUdp);
            if (r_offset == OffPortHi)   n_port_high   = i_data_byte;
            if (r_offset == OffPortLo)   n_port_ok     = (port == PortEvent)
                                                      || (port == PortGeneral);
            if (r_offset == OffMsgType)  n_type_ok = (i_data_byte == MsgSync)
                                                  || (i_data_byte == MsgDelayReq)
                                                  || (i_data_byte == MsgDelayResp);
            if (r_offset == OffVersion)  n_version_ok = (i_data_byte == PtpVersion2);

            priority if (in_field && r_offset == OffCorrLast) begin
                // whole field seen: emit the corrected value
                o_push    = 1'b1;
                o_job     = '{data: hold_shift + i_residence_ns, cnt: CntSum,
                              last: i_last_byte, upd: 1'b1};
                n_holding = 1'b0;
                n_updated = 1'b1;
            end else if (in_field && i_last_byte) begin
                // packet cut short inside the field: release it untouched
                o_push    = 1'b1;
                o_job     = '{data: hold_shift, cnt: 4'(r_offset - CorrBase),
                              last: 1'b1, upd: 1'b0};
                n_holding = 1'b0;
            end else if (in_field) begin
                n_holding = 1'b1;
                n_hold    = hold_shift;
            end else begin
                o_push = 1'b1;
            end

            if (i_last_byte) begin
                n_offset      = '0;
                n_protocol_ok = 1'b0;
                n_port_high   = '0;
                n_port_ok     = 1'b0;
                n_type_ok     = 1'b0;
                n_version_ok  = 1'b0;
                n_hold        = '0;
                n_holding     = 1'b0;
                n_updated     = 1'b0;
            end else if (r_offset != OffMax) begin
                n_offset = r_offset + 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset      <= '0;
            r_protocol_ok <= 1'b0;
            r_port_high   <= '0;
            r_port_ok     <= 1'b0;
            r_type_ok     <= 1'b0;
            r_version_ok  <= 1'b0;
            r_hold        <= '0;
            r_holding     <= 1'b0;
            r_updated     <= 1'b0;
        end else begin
            r_offset      <= n_offset;
            r_protocol_ok <= n_protocol_ok;
            r_port_high   <= n_port_high;
            r_port_ok     <= n_port_ok;
            r_type_ok     <= n_type_ok;
            r_version_ok  <= n_version_ok;
            r_hold        <= n_hold;
            r_holding     <= n_holding;
            r_updated     <= n_updated;
        end
    end

endmodule

// ===== design/ptpcf_queue.sv =====
// Job queue between front and back ends, register based.
// Depends on ptpcf_pkg and the assertion macro header.
`include "ptp_correction_field_updater_defines.svh"
module ptpcf_queue #(
    parameter int unsigned DEPTH = ptpcf_pkg::QueueDepth
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ptpcf_pkg::t_job   i_job,
    output logic              o_full,
    input  logic              i_pop,
    output ptpcf_pkg::t_job   o_head,
    output logic              o_empty
);
    import ptpcf_pkg::*;

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

    t_job            r_mem [DEPTH];
    logic [PtrW-1:0] r_wr, n_wr;
    logic [PtrW-1:0] r_rd, n_rd;
    logic [CntW-1:0] r_count, n_count;

    assign o_full  = (r_count == CntFull);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) n_wr = (r_wr == PtrLast) ? '0 : r_wr + PtrW'(1);
        if (i_pop)  n_rd = (r_rd == PtrLast) ? '0 : r_rd + PtrW'(1);
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + CntW'(1);
            2'b01:   n_count = r_count - CntW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    `PTPCF_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && o_full)
    `PTPCF_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && o_empty)
    `PTPCF_ASSERT(a_count_range, i_clk, i_rst_n, r_count <= CntFull)
    `PTPCF_ASSERT(a_push_fills, i_clk, i_rst_n, (i_push && !i_pop) |=> !o_empty)

endmodule

// ===== design/ptpcf_back.sv =====
// Back end: unrolls queued jobs into output bytes, one per cycle unless the output stalls.
// Depends on ptpcf_pkg.
module ptpcf_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ptpcf_pkg::t_job   i_head,
    input  logic              i_empty,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [7:0]        o_out_byte,
    output logic              o_out_last,
    output logic              o_was_updated
);
    import ptpcf_pkg::*;

    t_job        r_cur, n_cur;
    logic        r_busy, n_busy;
    logic [3:0]  r_rem, n_rem;
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_byte, n_out_byte;
    logic        r_out_last, n_out_last;
    logic        r_out_upd, n_out_upd;

    logic        adv;
    logic        have;
    t_job        src;
    logic [3:0]  rem;
    logic [2:0]  idx;

    assign adv  = !r_out_valid || !i_out_stall;
    assign have = r_busy || !i_empty;
    assign src  = r_busy ? r_cur : i_head;
    assign rem  = r_busy ? r_rem : i_head.cnt;
    assign idx  = 3'(rem - 4'd1);

    assign o_pop = adv && !r_busy && !i_empty;

    always_comb begin
        n_cur       = r_cur;
        n_busy      = r_busy;
        n_rem       = r_rem;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_out_upd   = r_out_upd;
        if (adv) begin
            n_out_valid = have;
            if (have) begin
                n_out_byte = src.data[{idx, 3'b000} +: 8];
                n_out_last = src.last && (rem == 4'd1);
                n_out_upd  = src.upd;
                n_cur      = src;
                n_rem      = rem - 4'd1;
                n_busy     = (rem != 4'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_rem       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_rem       <= n_rem;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
        r_out_upd  <= n_out_upd;
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_out_last    = r_out_last;
    assign o_was_updated = r_out_upd;

endmodule

// ===== test/ptp_correction_field_updater_test.sv =====
// Self-checking bench for ptp_correction_field_updater: byte streams in, byte streams out.
// Depends on ptpcf_pkg and the RTL only; a behavioural tracker of the frame state
// predicts every output transaction.
module ptp_correction_field_updater_test;
    import ptpcf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // number of idle cycles in a row before the run is declared hung
    localparam int unsigned HangLimit   = 2000;
    // settling time after the last output: the input-to-output latency plus margin
    localparam int unsigned TailCycles  = 16;
    // random traffic on top of the directed frames: at least this many bytes
    localparam int unsigned RandomBytes = 60;

    // one pending input transaction; a hold-off entry makes the sender wait for a drain
    typedef struct {
        logic [7:0]  data;
        logic        last;
        logic [15:0] len;
        logic [63:0] res;
        bit          holdoff;
    } t_link_byte;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       upd;
    } t_egress_byte;

    typedef enum logic [1:0] {
        SinkFree,
        SinkSparse,
        SinkPeriodic,
        SinkChoked
    } t_sink_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte = '0;
    logic        i_last_byte = 1'b0;
    logic [15:0] i_packet_length = '0;
    logic [63:0] i_residence_ns = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_out_last;
    logic        o_was_updated;

    ptp_correction_field_updater dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_last_byte     (i_last_byte),
        .i_packet_length (i_packet_length),
        .i_residence_ns  (i_residence_ns),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_byte      (o_out_byte),
        .o_out_last      (o_out_last),
        .o_was_updated   (o_was_updated)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_link_byte   ingress_backlog[$];
    t_egress_byte egress_due[$];
    logic [7:0]   frame_buf[$];

    int unsigned mismatch_count;
    int unsigned frames_queued;
    int unsigned bytes_accepted;
    int unsigned fields_rewritten;
    int unsigned fields_cut;
    int unsigned idle_cycles;

    // ------------------------------------------------------------------
    // Frame tracker: mirrors the header checks and the correction hold
    // ------------------------------------------------------------------
    logic [15:0] trk_offset;
    logic        trk_proto_ok;
    logic [7:0]  trk_port_hi;
    logic        trk_port_ok;
    logic        trk_type_ok;
    logic        trk_ver_ok;
    logic [63:0] trk_corr;
    logic        trk_holding;
    logic        trk_updated;

    task automatic clear_tracker();
        trk_offset   = '0;
        trk_proto_ok = 1'b0;
        trk_port_hi  = '0;
        trk_port_ok  = 1'b0;
        trk_type_ok  = 1'b0;
        trk_ver_ok   = 1'b0;
        trk_corr     = '0;
        trk_holding  = 1'b0;
        trk_updated  = 1'b0;
    endtask

    // Advances the tracker by one accepted byte and queues the bytes it releases.
    task automatic follow_frame(input logic [7:0] b, input logic lst,
                                input logic [15:0] len, input logic [63:0] res);
        logic [15:0] off;
        logic [63:0] sum;
        logic [63:0] shifted;
        int          cnt;
        off = trk_offset;
        if (off == OffProtocol) trk_proto_ok = (b == IpProtoUdp);
        if (off == OffPortHi)   trk_port_hi = b;
        if (off == OffPortLo)
            trk_port_ok = ({trk_port_hi, b} == PortEvent) || ({trk_port_hi, b} == PortGeneral);
        if (off == OffMsgType)
            trk_type_ok = (b == MsgSync) || (b == MsgDelayReq) || (b == MsgDelayResp);
        if (off == OffVersion)  trk_ver_ok = (b == PtpVersion2);

        // the decision uses the length carried by byte 36 itself
        if (off == OffCorrFirst && len >= MinLength && trk_proto_ok && trk_port_ok &&
            trk_type_ok && trk_ver_ok) begin
            trk_holding = 1'b1;
            trk_corr    = '0;
        end

        if (trk_holding && off >= OffCorrFirst && off <= OffCorrLast) begin
            trk_corr = {trk_corr[55:0], b};
            if (off == OffCorrLast) begin
                sum = trk_corr + res;
                for (int i = 0; i < 8; i++)
                    egress_due.push_back({sum[63 - 8 * i -: 8], (i == 7) ? lst : 1'b0, 1'b1});
                trk_holding = 1'b0;
                trk_updated = 1'b1;
                fields_rewritten++;
            end else if (lst) begin
                // frame ended inside the field: release what was held, untouched
                cnt = int'(off - CorrBase);
                for (int i = 0; i < cnt; i++) begin
                    shifted = trk_corr >> (8 * (cnt - 1 - i));
                    egress_due.push_back({shifted[7:0], (i == cnt - 1), 1'b0});
                end
                trk_holding = 1'b0;
                fields_cut++;
            end
        end else begin
            egress_due.push_back({b, lst, trk_updated});
        end

        if (lst) clear_tracker();
        else if (trk_offset != OffMax) trk_offset = off + 16'd1;
    endtask

    // ------------------------------------------------------------------
    // Frame construction
    // ------------------------------------------------------------------
    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [7:0] pick_msg_type();
        case ($urandom_range(0, 2))
            0:       return MsgSync;
            1:       return MsgDelayReq;
            default: return MsgDelayResp;
        endcase
    endfunction

    // random bytes with a qualifying header laid over whatever fits
    task automatic start_frame(input int n);
        logic [15:0] port;
        frame_buf.delete();
        for (int i = 0; i < n; i++) frame_buf.push_back(8'($urandom_range(0, 255)));
        port = $urandom_range(0, 1) ? PortEvent : PortGeneral;
        if (n > OffProtocol) frame_buf[OffProtocol] = IpProtoUdp;
        if (n > OffPortLo) begin
            frame_buf[OffPortHi] = port[15:8];
            frame_buf[OffPortLo] = port[7:0];
        end
        if (n > OffMsgType) frame_buf[OffMsgType] = pick_msg_type();
        if (n > OffVersion) frame_buf[OffVersion] = PtpVersion2;
    endtask

    task automatic set_correction(input logic [63:0] corr);
        for (int i = 0; i < 8; i++)
            if (frame_buf.size() > OffCorrFirst + i)
                frame_buf[OffCorrFirst + i] = corr[63 - 8 * i -: 8];
    endtask

    // Queues frame_buf. When jittery, each byte carries a random length unless it is
    // byte 36 and a random residence time unless it is byte 43, where the block samples them.
    task automatic send_frame(input logic [15:0] len, input logic [63:0] res, input bit jittery);
        t_link_byte item;
        for (int i = 0; i < frame_buf.size(); i++) begin
            item.data    = frame_buf[i];
            item.last    = (i == frame_buf.size() - 1);
            item.len     = (jittery && i != OffCorrFirst) ? 16'($urandom) : len;
            item.res     = (jittery && i != OffCorrLast) ? rand64() : res;
            item.holdoff = 1'b0;
            ingress_backlog.push_back(item);
        end
        frames_queued++;
    endtask

    task automatic queue_drain_pause();
        t_link_byte item;
        item = '{data: '0, last: 1'b0, len: '0, res: '0, holdoff: 1'b1};
        ingress_backlog.push_back(item);
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of transactions with random gaps, changes at negedge
    // ------------------------------------------------------------------
    logic       in_taken = 1'b0;
    int         burst_left;
    int         gap_left;
    t_link_byte head;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_taken) begin
            // stalled: payload and valid hold
        end else if (gap_left > 0) begin
            gap_left--;
            i_in_valid <= 1'b0;
        end else if (ingress_backlog.size() == 0) begin
            i_in_valid <= 1'b0;
        end else if (ingress_backlog[0].holdoff) begin
            i_in_valid <= 1'b0;
            if (egress_due.size() == 0) void'(ingress_backlog.pop_front());
        end else begin
            head = ingress_backlog.pop_front();
            i_in_valid      <= 1'b1;
            i_data_byte     <= head.data;
            i_last_byte     <= head.last;
            i_packet_length <= head.len;
            i_residence_ns  <= head.res;
            if (burst_left == 0) burst_left = $urandom_range(1, 60);
            burst_left--;
            if (burst_left == 0)
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall: a mode held for a random stretch of cycles
    // ------------------------------------------------------------------
    t_sink_mode sink_mode = SinkFree;
    int         sink_span;

    always @(negedge i_clk) begin
        if (sink_span == 0) begin
            sink_span = $urandom_range(16, 96);
            case ($urandom_range(0, 3))
                0:       sink_mode = SinkFree;
                1:       sink_mode = SinkSparse;
                2:       sink_mode = SinkPeriodic;
                default: sink_mode = SinkChoked;
            endcase
        end
        sink_span--;
        case (sink_mode)
            SinkFree:     i_out_stall <= 1'b0;
            SinkSparse:   i_out_stall <= ($urandom_range(0, 2) == 0);
            SinkPeriodic: i_out_stall <= (sink_span % 5 < 2);
            default:      i_out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // ------------------------------------------------------------------
    // Monitor: checks outputs, feeds the tracker, guards against hangs
    // ------------------------------------------------------------------
    t_egress_byte due;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken    <= 1'b0;
            idle_cycles = 0;
        end else begin
            in_taken <= i_in_valid && !o_in_stall;

            if (o_out_valid && !i_out_stall) begin
                if (egress_due.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: output transaction with none due: byte %02h last %0b upd %0b",
                             $time, o_out_byte, o_out_last, o_was_updated);
                end else begin
                    due = egress_due.pop_front();
                    if (o_out_byte !== due.data) begin
                        mismatch_count++;
                        $display("%0t: out_byte expected %02h actual %02h",
                                 $time, due.data, o_out_byte);
                    end
                    if (o_out_last !== due.last) begin
                        mismatch_count++;
                        $display("%0t: out_last expected %0b actual %0b",
                                 $time, due.last, o_out_last);
                    end
                    if (o_was_updated !== due.upd) begin
                        mismatch_count++;
                        $display("%0t: was_updated expected %0b actual %0b",
                                 $time, due.upd, o_was_updated);
                    end
                end
            end

            if (i_in_valid && !o_in_stall) begin
                follow_frame(i_data_byte, i_last_byte, i_packet_length, i_residence_ns);
                bytes_accepted++;
            end

            if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall)) idle_cycles = 0;
            else idle_cycles++;

            if (idle_cycles >= HangLimit) begin
                $display("%0t: no transaction for %0d cycles, %0d output bytes still due",
                         $time, idle_cycles, egress_due.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    int         n;
    int         kind;
    int unsigned random_bytes;
    bit         paused_midway;
    logic [15:0] len;

    initial begin
        clear_tracker();

        // --- directed frames ---
        start_frame(1);
        send_frame(16'd1, 64'd0, 1'b0);                 // one-byte frame
        // sum wraps past 2^64 and the frame ends on the field's last byte
        start_frame(44);
        frame_buf[OffMsgType] = MsgSync;
        frame_buf[OffPortLo] = PortEvent[7:0]; frame_buf[OffPortHi] = PortEvent[15:8];
        set_correction('1);
        send_frame(MinLength, 64'd1, 1'b0);
        // frame that ends part-way through the held correction field
        start_frame(40);
        send_frame(16'd200, rand64(), 1'b0);
        // length and residence vary byte to byte; only bytes 36 and 43 count
        start_frame(48); send_frame(MinLength, rand64(), 1'b1);
        queue_drain_pause();

        // --- random frames: mostly well formed, some broken, some noise ---
        random_bytes  = 0;
        paused_midway = 1'b0;
        while (random_bytes < RandomBytes) begin
            kind = $urandom_range(0, 99);
            if (kind < 85) begin
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(37, 43) : $urandom_range(44, 64);
                start_frame(n);
                len = ($urandom_range(0, 4) == 0) ? MinLength : 16'($urandom_range(62, 65535));
                if (kind >= 65) begin
                    case ($urandom_range(0, 5))
                        0: frame_buf[OffProtocol] = IpProtoUdp ^ 8'($urandom_range(1, 255));
                        1: frame_buf[OffPortHi] = frame_buf[OffPortHi] ^ 8'($urandom_range(1, 255));
                        2: frame_buf[OffPortLo] = frame_buf[OffPortLo] ^ 8'($urandom_range(1, 255));
                        3: frame_buf[OffMsgType] = 8'($urandom_range(0, 255));
                        4: frame_buf[OffVersion] = PtpVersion2 ^ 8'($urandom_range(1, 255));
                        default: len = 16'($urandom_range(0, 61));
                    endcase
                end
                send_frame(len, ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 1000)) :
                           rand64(), ($urandom_range(0, 3) == 0));
            end else begin
                n = $urandom_range(1, 80);
                frame_buf.delete();
                for (int i = 0; i < n; i++) frame_buf.push_back(8'($urandom_range(0, 255)));
                send_frame(16'($urandom), rand64(), 1'b1);
            end
            random_bytes += n;
            if (!paused_midway && random_bytes >= RandomBytes / 2) begin
                queue_drain_pause();
                paused_midway = 1'b1;
            end
        end

        // reset held from time zero, released at a falling edge
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (ingress_backlog.size() != 0 || i_in_valid) @(posedge i_clk);
        while (egress_due.size() != 0) @(posedge i_clk);
        repeat (TailCycles) @(posedge i_clk);

        $display("Streamed %0d frames, %0d bytes: %0d correction fields rewritten,",
                 frames_queued, bytes_accepted, fields_rewritten);
        $display("%0d frames cut inside the field, under bursty input and a stalling sink.",
                 fields_cut);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
